[sv/t2r_pkg.sv]
// Shared types and constants for the tiled-to-raster remapper.
package t2r_pkg;

  localparam int MAX_WIDTH_TILES_DEF = 128;
  localparam int MAX_HEIGHT_DEF      = 8192;

  localparam int TILE       = 32;
  localparam int TILE_LOG2  = 5;
  localparam int ADDR_W     = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [TILE_LOG2-1:0] POS_LAST = TILE_LOG2'(TILE - 1);

  localparam logic [7:0]  WIDTH_TILES_RST  = 8'd40;
  localparam logic [13:0] HEIGHT_LINES_RST = 14'd720;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH_TILES  = 2'd0,
    CFG_HEIGHT_LINES = 2'd1,
    CFG_PLANE_MODE   = 2'd2
  } t2r_cfg_idx_t;

  typedef enum logic [1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } t2r_plane_t;

  // Wrap flags of the tile position counter for the current byte.
  typedef struct packed {
    logic col_last;
    logic row_last;
    logic frame_last;
  } t2r_pos_flags_t;

endpackage

[sv/t2r_if.sv]
// Valid/ready channel interfaces for source bytes and remapped results.
interface t2r_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;

  modport source (output valid, output src_byte, input ready);
  modport sink   (input valid, input src_byte, output ready);
endinterface

interface t2r_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 dest_plane;
  logic [t2r_pkg::ADDR_W-1:0] dest_address;
  logic [7:0]                 pixel_value;
  logic                       write_enable;
  logic                       frame_last;

  modport source (output valid, output dest_plane, output dest_address,
                  output pixel_value, output write_enable, output frame_last,
                  input ready);
  modport sink   (input valid, input dest_plane, input dest_address,
                  input pixel_value, input write_enable, input frame_last,
                  output ready);
endinterface

[sv/t2r_tile_ctr.sv]
// Tile-order position counter: byte, row in tile, tile column, tile row.
module t2r_tile_ctr #(
  parameter int COL_W  = 7,
  parameter int TROW_W = 8,
  parameter int WT_W   = 8,
  parameter int TR_W   = 9
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            advance,
  input  logic [WT_W-1:0]                 width_tiles,
  input  logic [TR_W-1:0]                 tile_rows,
  output logic [t2r_pkg::TILE_LOG2-1:0]   byte_in_row,
  output logic [t2r_pkg::TILE_LOG2-1:0]   row_in_tile,
  output logic [COL_W-1:0]                tile_column,
  output logic [TROW_W-1:0]               tile_row,
  output t2r_pkg::t2r_pos_flags_t         flags
);

  localparam int CW = (COL_W > WT_W ? COL_W : WT_W) + 1;
  localparam int RW = (TROW_W > TR_W ? TROW_W : TR_W) + 1;

  logic [t2r_pkg::TILE_LOG2-1:0] bir_r, bir_nxt;
  logic [t2r_pkg::TILE_LOG2-1:0] rit_r, rit_nxt;
  logic [COL_W-1:0]              col_r, col_nxt;
  logic [TROW_W-1:0]             trow_r, trow_nxt;
  logic                          col_last, row_last;

  // a column or tile row at or past the last one (config change) wraps
  assign col_last = (CW'(col_r) + CW'(1)) >= CW'(width_tiles);
  assign row_last = (RW'(trow_r) + RW'(1)) >= RW'(tile_rows);

  always_comb begin
    bir_nxt  = bir_r;
    rit_nxt  = rit_r;
    col_nxt  = col_r;
    trow_nxt = trow_r;
    if (advance) begin
      if (bir_r != t2r_pkg::POS_LAST) begin
        bir_nxt = bir_r + 1'b1;
      end else begin
        bir_nxt = '0;
        if (rit_r != t2r_pkg::POS_LAST) begin
          rit_nxt = rit_r + 1'b1;
        end else begin
          rit_nxt = '0;
          if (!col_last) begin
            col_nxt = col_r + 1'b1;
          end else begin
            col_nxt  = '0;
            trow_nxt = row_last ? '0 : trow_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bir_r  <= '0;
      rit_r  <= '0;
      col_r  <= '0;
      trow_r <= '0;
    end else begin
      bir_r  <= bir_nxt;
      rit_r  <= rit_nxt;
      col_r  <= col_nxt;
      trow_r <= trow_nxt;
    end
  end

  assign byte_in_row      = bir_r;
  assign row_in_tile      = rit_r;
  assign tile_column      = col_r;
  assign tile_row         = trow_r;
  assign flags.col_last   = col_last;
  assign flags.row_last   = row_last;
  assign flags.frame_last = (bir_r == t2r_pkg::POS_LAST) && (rit_r == t2r_pkg::POS_LAST)
                            && col_last && row_last;

endmodule

[sv/tiled_mb32_to_raster_remap.sv]
// Bytes in 32x32 tile order give one raster placement each: one byte per clock
// when the output is not stalled; the single multiply-add stage (row times pitch
// plus column offset) lies between the capture register and the result register;
// a new transaction is taken every clock while the result register drains.
module tiled_mb32_to_raster_remap #(
  parameter int MAX_WIDTH_TILES = t2r_pkg::MAX_WIDTH_TILES_DEF,
  parameter int MAX_HEIGHT      = t2r_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [t2r_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [t2r_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  t2r_in_if.sink                            in_chan,
  t2r_out_if.source                         out_chan
);

  localparam int TL      = t2r_pkg::TILE_LOG2;
  localparam int WT_W    = $clog2(MAX_WIDTH_TILES + 1);
  localparam int COL_W   = (MAX_WIDTH_TILES > 1) ? $clog2(MAX_WIDTH_TILES) : 1;
  localparam int TR_MAX  = (MAX_HEIGHT + t2r_pkg::TILE - 1) / t2r_pkg::TILE;
  localparam int TROW_W  = (TR_MAX > 1) ? $clog2(TR_MAX) : 1;
  localparam int TR_W    = $clog2(TR_MAX + 1);
  localparam int H_W     = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W   = TROW_W + TL;
  localparam int PITCH_W = WT_W + TL;
  localparam int PROD_W  = ROW_W + PITCH_W;
  localparam int SUM_W   = (PROD_W > t2r_pkg::ADDR_W ? PROD_W : t2r_pkg::ADDR_W) + 1;
  localparam int CMP_W   = (ROW_W > H_W ? ROW_W : H_W);

  // configuration
  logic [7:0]  width_tiles_r;
  logic [13:0] height_lines_r;
  logic        plane_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_tiles_r  <= t2r_pkg::WIDTH_TILES_RST;
      height_lines_r <= t2r_pkg::HEIGHT_LINES_RST;
      plane_mode_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (t2r_pkg::t2r_cfg_idx_t'(cfg_index))
        t2r_pkg::CFG_WIDTH_TILES:  width_tiles_r  <= cfg_wdata[7:0];
        t2r_pkg::CFG_HEIGHT_LINES: height_lines_r <= cfg_wdata[13:0];
        t2r_pkg::CFG_PLANE_MODE:   plane_mode_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [WT_W-1:0] wt_eff;
  logic [H_W-1:0]  h_eff;
  logic [H_W-1:0]  rows_vis;
  logic [TR_W-1:0] tile_rows;

  always_comb begin
    if (width_tiles_r == 8'd0)
      wt_eff = WT_W'(1);
    else if (32'(width_tiles_r) > 32'(MAX_WIDTH_TILES))
      wt_eff = WT_W'(MAX_WIDTH_TILES);
    else
      wt_eff = WT_W'(width_tiles_r);

    if (height_lines_r < 14'd2)
      h_eff = H_W'(2);
    else if (32'(height_lines_r) > 32'(MAX_HEIGHT))
      h_eff = H_W'(MAX_HEIGHT);
    else
      h_eff = H_W'(height_lines_r);

    rows_vis  = plane_mode_r ? (h_eff >> 1) : h_eff;
    tile_rows = TR_W'((32'(rows_vis) + 32'(t2r_pkg::TILE - 1)) >> TL);
  end

  // handshake and pipeline control
  logic s1_valid_r, out_valid_r;
  logic out_take, s1_take, in_acc;

  assign out_take       = !out_valid_r || out_chan.ready;
  assign s1_take        = !s1_valid_r || out_take;
  assign in_chan.ready  = s1_take;
  assign in_acc         = in_chan.valid && s1_take;

  // position counter
  logic [TL-1:0]              pos_bir, pos_rit;
  logic [COL_W-1:0]           pos_col;
  logic [TROW_W-1:0]          pos_trow;
  t2r_pkg::t2r_pos_flags_t    pos_flags;

  t2r_tile_ctr #(
    .COL_W  (COL_W),
    .TROW_W (TROW_W),
    .WT_W   (WT_W),
    .TR_W   (TR_W)
  ) u_ctr (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (in_acc),
    .width_tiles (wt_eff),
    .tile_rows   (tile_rows),
    .byte_in_row (pos_bir),
    .row_in_tile (pos_rit),
    .tile_column (pos_col),
    .tile_row    (pos_trow),
    .flags       (pos_flags)
  );

  // capture stage
  logic [7:0]        s1_byte_r;
  logic [TL-1:0]     s1_bir_r, s1_rit_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [TROW_W-1:0] s1_trow_r;
  logic              s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n)
      s1_valid_r <= 1'b0;
    else if (s1_take)
      s1_valid_r <= in_chan.valid;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_chan.src_byte;
      s1_bir_r  <= pos_bir;
      s1_rit_r  <= pos_rit;
      s1_col_r  <= pos_col;
      s1_trow_r <= pos_trow;
      s1_last_r <= pos_flags.frame_last;
    end
  end

  // address: row * pitch + column offset; chroma halves pitch and byte index
  logic [ROW_W-1:0]       row;
  logic [PITCH_W-1:0]     pitch;
  logic [COL_W+TL-1:0]    offs;
  logic [PROD_W-1:0]      prod;
  logic [SUM_W-1:0]       sum;
  logic                   row_vis, we;
  t2r_pkg::t2r_plane_t    plane;

  always_comb begin
    row     = {s1_trow_r, s1_rit_r};
    pitch   = plane_mode_r ? PITCH_W'({wt_eff, 4'b0}) : {wt_eff, 5'b0};
    offs    = plane_mode_r ? (COL_W+TL)'({s1_col_r, s1_bir_r[TL-1:1]})
                           : {s1_col_r, s1_bir_r};
    prod    = PROD_W'(row) * PROD_W'(pitch);
    sum     = SUM_W'(prod) + SUM_W'(offs);
    row_vis = CMP_W'(row) < CMP_W'(rows_vis);
    we      = !plane_mode_r || row_vis;
    if (!plane_mode_r)
      plane = t2r_pkg::PLANE_Y;
    else
      plane = s1_bir_r[0] ? t2r_pkg::PLANE_V : t2r_pkg::PLANE_U;
  end

  // result register
  logic [1:0]                 out_plane_r;
  logic [t2r_pkg::ADDR_W-1:0] out_addr_r;
  logic [7:0]                 out_byte_r;
  logic                       out_we_r, out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (out_take)
      out_valid_r <= s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (out_take && s1_valid_r) begin
      out_plane_r <= plane;
      out_addr_r  <= we ? sum[t2r_pkg::ADDR_W-1:0] : '0;
      out_byte_r  <= s1_byte_r;
      out_we_r    <= we;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.dest_plane   = out_plane_r;
  assign out_chan.dest_address = out_addr_r;
  assign out_chan.pixel_value  = out_byte_r;
  assign out_chan.write_enable = out_we_r;
  assign out_chan.frame_last   = out_last_r;

  // checks
  a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && pos_flags.frame_last |=>
      pos_bir == '0 && pos_rit == '0 && pos_col == '0 && pos_trow == '0)
    else $error("counters did not wrap after end of frame");

  a_discard_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_we_r |-> out_addr_r == '0)
    else $error("discarded byte carries nonzero address");

  a_plane_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_plane_r != 2'd3)
    else $error("invalid destination plane");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_chan.ready |-> !in_chan.ready)
    else $error("input accepted with both stages full");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_take |=> out_valid_r)
    else $error("captured transaction lost");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the tiled-to-raster remapper.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import t2r_pkg::*;

  typedef struct packed {
    t2r_plane_t        plane;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        pix;
    logic              we;
    logic              last;
  } placement_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  t2r_in_if  in_chan();
  t2r_out_if out_chan();

  tiled_mb32_to_raster_remap u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  // Register copies as the block sees them
  logic [7:0]  width_tiles_reg;
  logic [13:0] height_lines_reg;
  logic        chroma_mode_reg;

  // Position of the next source byte in tile order
  logic [4:0] pos_byte;
  logic [4:0] pos_row;
  logic [6:0] pos_col;
  logic [7:0] pos_tile_row;

  logic [7:0] pending_bytes[$];
  placement_t pending_placements[$];
  int         errors;
  bit         no_gaps;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic note_error(input string msg);
    if (errors < 10) $display("%s", msg);
    errors++;
  endtask

  // Works out where one source byte lands, then steps the tile position.
  function automatic void place_byte(input logic [7:0] b);
    int unsigned wt, h, vis_rows, tile_rows, row, addr;
    bit          col_last, row_last;
    placement_t  p;
    wt = (width_tiles_reg == 0) ? 1 : int'(width_tiles_reg);
    if (wt > MAX_WIDTH_TILES_DEF) wt = MAX_WIDTH_TILES_DEF;
    h = (height_lines_reg < 2) ? 2 : int'(height_lines_reg);
    if (h > MAX_HEIGHT_DEF) h = MAX_HEIGHT_DEF;
    vis_rows = chroma_mode_reg ? (h >> 1) : h;
    tile_rows = (vis_rows + TILE - 1) / TILE;
    if (tile_rows < 1) tile_rows = 1;
    row = int'(pos_tile_row) * TILE + int'(pos_row);

    p.pix = b;
    p.we  = 1'b1;
    if (!chroma_mode_reg) begin
      p.plane = PLANE_Y;
      addr = row * (wt * TILE) + int'(pos_col) * TILE + int'(pos_byte);
    end else begin
      p.plane = pos_byte[0] ? PLANE_V : PLANE_U;
      if (row < vis_rows) begin
        addr = row * (wt * (TILE / 2)) + int'(pos_col) * (TILE / 2) + int'(pos_byte >> 1);
      end else begin
        addr = 0;
        p.we = 1'b0;
      end
    end
    p.addr = addr[ADDR_W-1:0];

    col_last = int'(pos_col) + 1 >= wt;
    row_last = int'(pos_tile_row) + 1 >= tile_rows;
    p.last = (pos_byte == POS_LAST) && (pos_row == POS_LAST) && col_last && row_last;
    pending_placements.push_back(p);

    if (pos_byte != POS_LAST) begin
      pos_byte++;
    end else begin
      pos_byte = '0;
      if (pos_row != POS_LAST) begin
        pos_row++;
      end else begin
        pos_row = '0;
        if (!col_last) begin
          pos_col++;
        end else begin
          pos_col = '0;
          pos_tile_row = row_last ? 8'd0 : pos_tile_row + 8'd1;
        end
      end
    end
  endfunction

  // Source side: one transaction per handshake, random gaps unless no_gaps is set
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid    <= 1'b0;
      in_chan.src_byte <= '0;
    end else begin
      if (in_chan.valid && in_chan.ready) place_byte(in_chan.src_byte);
      if (!in_chan.valid || in_chan.ready) begin
        if (pending_bytes.size() != 0 && (no_gaps || $urandom_range(99) >= 38)) begin
          in_chan.valid    <= 1'b1;
          in_chan.src_byte <= pending_bytes.pop_front();
        end else begin
          in_chan.valid    <= 1'b0;
          in_chan.src_byte <= 8'($urandom);
        end
      end
    end
  end

  // Result side: random backpressure unless no_gaps is set, compare against the oldest expectation
  always @(posedge clk) begin
    placement_t got, want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got.plane = t2r_plane_t'(out_chan.dest_plane);
        got.addr  = out_chan.dest_address;
        got.pix   = out_chan.pixel_value;
        got.we    = out_chan.write_enable;
        got.last  = out_chan.frame_last;
        if (pending_placements.size() == 0) begin
          note_error($sformatf("unexpected result: plane %0d addr %0h pix %0h we %0b last %0b",
                               got.plane, got.addr, got.pix, got.we, got.last));
        end else begin
          want = pending_placements.pop_front();
          if (got !== want)
            note_error($sformatf({"mismatch: plane %0d/%0d addr %0h/%0h pix %0h/%0h ",
                                  "we %0b/%0b last %0b/%0b (expected/actual)"},
                                 want.plane, got.plane, want.addr, got.addr, want.pix,
                                 got.pix, want.we, got.we, want.last, got.last));
        end
      end
      out_chan.ready <= no_gaps || ($urandom_range(99) >= 38);
    end
  end

  // Called at a rising edge; returns at a rising edge with the write done.
  task automatic write_reg(input t2r_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_WIDTH_TILES:  width_tiles_reg  = val[7:0];
      CFG_HEIGHT_LINES: height_lines_reg = val;
      CFG_PLANE_MODE:   chroma_mode_reg  = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_chan.valid || pending_placements.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_random(input int n);
    repeat (n) pending_bytes.push_back(8'($urandom));
    settle();
  endtask

  initial begin
    int n;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_WIDTH_TILES;
    cfg_wdata        = '0;
    in_chan.valid    = 1'b0;
    in_chan.src_byte = '0;
    out_chan.ready   = 1'b0;
    no_gaps          = 1'b0;
    errors           = 0;
    width_tiles_reg  = WIDTH_TILES_RST;
    height_lines_reg = HEIGHT_LINES_RST;
    chroma_mode_reg  = 1'b0;
    pos_byte         = '0;
    pos_row          = '0;
    pos_col          = '0;
    pos_tile_row     = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration, luma, extreme byte values
    pending_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA};
    settle();

    // Chroma split with zero width and the smallest height
    write_reg(CFG_WIDTH_TILES, 14'd0);
    write_reg(CFG_HEIGHT_LINES, 14'd2);
    write_reg(CFG_PLANE_MODE, 14'd1);
    pending_bytes = '{8'h7F, 8'hFE, 8'h3C, 8'hC3, 8'h0F, 8'hF0};
    settle();

    // Width and height above their maximum, back to luma
    write_reg(CFG_WIDTH_TILES, 14'h00FF);
    write_reg(CFG_HEIGHT_LINES, 14'h3FFF);
    write_reg(CFG_PLANE_MODE, 14'd0);
    pending_bytes = '{8'hFF, 8'h00, 8'hA5, 8'h5A};
    settle();

    // Widest picture with height below the minimum
    write_reg(CFG_WIDTH_TILES, 14'd128);
    write_reg(CFG_HEIGHT_LINES, 14'd1);
    pending_bytes = '{8'h12, 8'hED, 8'h81, 8'h7E};
    settle();

    // Tallest picture in chroma, unused upper bits set
    write_reg(CFG_WIDTH_TILES, 14'h3F01);
    write_reg(CFG_HEIGHT_LINES, 14'd8192);
    write_reg(CFG_PLANE_MODE, 14'h3FFF);
    pending_bytes = '{8'h33, 8'hCC, 8'h96, 8'h69};
    settle();

    // Luma on a single tile column, several rows of the tile
    write_reg(CFG_WIDTH_TILES, 14'd1);
    write_reg(CFG_HEIGHT_LINES, 14'd40);
    write_reg(CFG_PLANE_MODE, 14'd0);
    send_random(100 + $urandom_range(0, 16));

    // Two tile columns of chroma, partly hidden rows; no gaps on either side
    no_gaps = 1'b1;
    write_reg(CFG_WIDTH_TILES, 14'd2);
    write_reg(CFG_HEIGHT_LINES, 14'd12);
    write_reg(CFG_PLANE_MODE, 14'd1);
    send_random(100 + $urandom_range(0, 16));
    no_gaps = 1'b0;

    // Single visible chroma row, width and height clamped
    write_reg(CFG_WIDTH_TILES, 14'd0);
    write_reg(CFG_HEIGHT_LINES, 14'd0);
    send_random(40 + $urandom_range(0, 8));

    // Short bursts with the configuration changed mid-frame
    repeat (12) begin
      if ($urandom_range(1))
        write_reg(CFG_WIDTH_TILES, $urandom_range(1) ? 14'($urandom) : 14'($urandom_range(0, 4)));
      if ($urandom_range(1))
        write_reg(CFG_HEIGHT_LINES,
                  $urandom_range(1) ? 14'($urandom) : 14'($urandom_range(0, 100)));
      if ($urandom_range(1))
        write_reg(CFG_PLANE_MODE, 14'($urandom));
      n = $urandom_range(5, 15);
      send_random(n);
    end

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
